// ===== hdl/bbc_pkg.sv =====
// shared constants, codes and types for the bracket balance checker
package bbc_pkg;

    // stack sizing
    localparam int STACK_DEPTH = 1024;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int VERD_W  = 2;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_LBRACE   = 8'h7B;
    localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_LPAREN   = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_RBRACE   = 8'h7D;
    localparam logic [CHAR_W-1:0] CHAR_RBRACKET = 8'h5D;
    localparam logic [CHAR_W-1:0] CHAR_RPAREN   = 8'h29;

    // bracket shape codes held on the stack
    localparam logic [1:0] SHAPE_BRACE   = 2'd0;
    localparam logic [1:0] SHAPE_BRACKET = 2'd1;
    localparam logic [1:0] SHAPE_PAREN   = 2'd2;

    // operation kinds
    localparam logic [1:0] OP_OTHER = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    // verdict codes
    localparam logic [VERD_W-1:0] VERDICT_OK       = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_UNBAL    = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] shape;
        logic       last;
    } op_t;

endpackage

// ===== hdl/bbc_intf.sv =====
// request channel interfaces for characters in and results out
interface bbc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bbc_pkg::CHAR_W-1:0]    char_code;
    logic                          is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface bbc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bbc_pkg::VERD_W-1:0]    verdict;
    logic [bbc_pkg::COUNT_W-1:0]   bracket_count;

    modport source (output valid, output verdict, output bracket_count, input ready);
    modport sink   (input valid, input verdict, input bracket_count, output ready);
endinterface

// ===== hdl/bbc_front.sv =====
// front end: classifies each character into a push, pop or ignore operation
module bbc_front
(
    bbc_in_if.sink          char_in,
    output logic            op_valid,
    output bbc_pkg::op_t    op,
    input  logic            op_ready
);

    always_comb
    begin
        op.kind  = bbc_pkg::OP_OTHER;
        op.shape = bbc_pkg::SHAPE_BRACE;
        op.last  = char_in.is_last;
        unique case (char_in.char_code)
            bbc_pkg::CHAR_LBRACE:
            begin
                op.kind  = bbc_pkg::OP_PUSH;
                op.shape = bbc_pkg::SHAPE_BRACE;
            end
            bbc_pkg::CHAR_LBRACKET:
            begin
                op.kind  = bbc_pkg::OP_PUSH;
                op.shape = bbc_pkg::SHAPE_BRACKET;
            end
            bbc_pkg::CHAR_LPAREN:
            begin
                op.kind  = bbc_pkg::OP_PUSH;
                op.shape = bbc_pkg::SHAPE_PAREN;
            end
            bbc_pkg::CHAR_RBRACE:
            begin
                op.kind  = bbc_pkg::OP_POP;
                op.shape = bbc_pkg::SHAPE_BRACE;
            end
            bbc_pkg::CHAR_RBRACKET:
            begin
                op.kind  = bbc_pkg::OP_POP;
                op.shape = bbc_pkg::SHAPE_BRACKET;
            end
            bbc_pkg::CHAR_RPAREN:
            begin
                op.kind  = bbc_pkg::OP_POP;
                op.shape = bbc_pkg::SHAPE_PAREN;
            end
            default:
            begin
                op.kind  = bbc_pkg::OP_OTHER;
            end
        endcase
    end

    assign op_valid      = char_in.valid;
    assign char_in.ready = op_ready;

endmodule

// ===== hdl/bbc_queue.sv =====
// short operation queue between front and back
module bbc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  bbc_pkg::op_t    push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output bbc_pkg::op_t    pop_data,
    input  logic            pop_ready
);

    bbc_pkg::op_t                    slot_reg [bbc_pkg::QUEUE_DEPTH];
    logic [bbc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [bbc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [bbc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [bbc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [bbc_pkg::QCNT_W-1:0]      count_reg;
    logic [bbc_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/bbc_back.sv =====
// back end: bracket stack with registered top, verdict and result register
module bbc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  bbc_pkg::op_t    op,
    output logic            op_ready,
    bbc_out_if.source       result_out
);

    logic [1:0]                      stack_mem [bbc_pkg::STACK_DEPTH];

    logic [bbc_pkg::DEPTH_W-1:0]     depth_reg;
    logic [bbc_pkg::DEPTH_W-1:0]     depth_next;
    logic [1:0]                      top_reg;
    logic [1:0]                      top_next;
    logic [1:0]                      second_reg;
    logic                            mismatch_reg;
    logic                            mismatch_next;
    logic                            overflow_reg;
    logic                            overflow_next;
    logic [bbc_pkg::COUNT_W-1:0]     total_reg;
    logic [bbc_pkg::COUNT_W-1:0]     total_next;
    logic                            out_valid_reg;
    logic [bbc_pkg::VERD_W-1:0]      verdict_reg;
    logic [bbc_pkg::COUNT_W-1:0]     count_reg;

    logic                            fire;
    logic                            emit;
    logic                            wr_en;
    logic [bbc_pkg::ADDR_W-1:0]      wr_addr;
    logic [bbc_pkg::ADDR_W-1:0]      rd_addr;
    logic [bbc_pkg::DEPTH_W-1:0]     depth_less_one;
    logic [bbc_pkg::DEPTH_W-1:0]     rd_depth;
    logic [bbc_pkg::VERD_W-1:0]      res_verdict;
    logic [bbc_pkg::COUNT_W-1:0]     res_count;

    // a last character needs room in the result register
    assign op_ready = !op.last || !out_valid_reg || result_out.ready;
    assign fire     = op_valid && op_ready;
    assign emit     = fire && op.last;

    assign depth_less_one = depth_reg - 1'b1;
    assign wr_addr        = depth_less_one[bbc_pkg::ADDR_W-1:0];

    always_comb
    begin
        depth_next    = depth_reg;
        top_next      = top_reg;
        mismatch_next = mismatch_reg;
        overflow_next = overflow_reg;
        total_next    = total_reg;
        wr_en         = 1'b0;
        if (fire)
        begin
            if ((op.kind != bbc_pkg::OP_OTHER) && (total_reg != '1))
            begin
                total_next = total_reg + 1'b1;
            end
            unique case (op.kind)
                bbc_pkg::OP_PUSH:
                begin
                    if (depth_reg == bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        // old top drops into the memory
                        wr_en      = (depth_reg != '0);
                        top_next   = op.shape;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                bbc_pkg::OP_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        mismatch_next = 1'b1;
                    end
                    else
                    begin
                        if (top_reg != op.shape)
                        begin
                            mismatch_next = 1'b1;
                        end
                        top_next   = second_reg;
                        depth_next = depth_less_one;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (overflow_next)
        begin
            res_verdict = bbc_pkg::VERDICT_OVERFLOW;
        end
        else if (mismatch_next || (depth_next != '0))
        begin
            res_verdict = bbc_pkg::VERDICT_UNBAL;
        end
        else
        begin
            res_verdict = bbc_pkg::VERDICT_OK;
        end
        res_count = total_next;

        if (emit)
        begin
            depth_next    = '0;
            mismatch_next = 1'b0;
            overflow_next = 1'b0;
            total_next    = '0;
        end
    end

    // prefetch the entry just below the new top
    assign rd_depth = depth_next - 2'd2;
    assign rd_addr  = rd_depth[bbc_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            second_reg <= top_reg;
        end
        else
        begin
            second_reg <= stack_mem[rd_addr];
        end
        top_reg <= top_next;
        if (emit)
        begin
            verdict_reg <= res_verdict;
            count_reg   <= res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            mismatch_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg    <= depth_next;
            mismatch_reg <= mismatch_next;
            overflow_reg <= overflow_next;
            total_reg    <= total_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.verdict       = verdict_reg;
    assign result_out.bracket_count = count_reg;

endmodule

// ===== hdl/bracket_balance_checker_top.sv =====
// top level of the bracket balance checker
// Characters arrive one request per cycle on char_in and are taken at one per clock while
// the operation queue has room. Each character is classified on entry as an opening bracket,
// a closing bracket or anything else, and lands in a four-deep operation queue the same
// cycle. The back end drains the queue at one operation per cycle unless a result stall
// holds it: the top of the bracket stack lives in a register and the entry below it is
// prefetched from the stack memory every cycle (one write port, one registered read port),
// so pushes and pops can follow each other back to back. When the character flagged as last
// is executed, one result request (verdict and saturating bracket count) is loaded into the
// output register and all state clears for the next expression. The result register only
// holds up the back end when a result is still waiting and another last character
// comes up; ordinary characters keep flowing meanwhile. The stack memory needs no clearing
// pass after reset, since only entries pushed in the current expression are read.
module bracket_balance_checker_top
(
    input  logic        clk,
    input  logic        rst_n,
    bbc_in_if.sink      char_in,
    bbc_out_if.source   result_out
);

    // classified operation, front to queue
    logic            front_valid;
    bbc_pkg::op_t    front_op;
    logic            front_ready;

    // queued operation, queue to back end
    logic            back_valid;
    bbc_pkg::op_t    back_op;
    logic            back_ready;

    bbc_front u_front
    (
        .char_in  (char_in),
        .op_valid (front_valid),
        .op       (front_op),
        .op_ready (front_ready)
    );

    // decouples classification from stack execution
    bbc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_data  (front_op),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_data   (back_op),
        .pop_ready  (back_ready)
    );

    // stack, sticky flags, counter and result register
    bbc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (back_valid),
        .op         (back_op),
        .op_ready   (back_ready),
        .result_out (result_out)
    );

endmodule

// ===== hdl/bbc_checker.sv =====
// port-level checks for the bracket balance checker, bound to the top level
module bbc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_is_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bbc_pkg::VERD_W-1:0]    verdict,
    input logic [bbc_pkg::COUNT_W-1:0]   bracket_count
);

    // expressions taken but not yet answered
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && in_ready && in_is_last;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !res_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!last_in && res_out)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == bbc_pkg::VERDICT_OK || verdict == bbc_pkg::VERDICT_UNBAL ||
                       verdict == bbc_pkg::VERDICT_OVERFLOW))
        else $error("verdict code out of range");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 4'd0))
        else $error("result shown without a pending last character");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(bbc_pkg::QUEUE_DEPTH + 1))
        else $error("more expressions pending than the queue and result register hold");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(bracket_count)))
        else $error("stalled result changed");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (char_in.valid),
    .in_ready      (char_in.ready),
    .in_is_last    (char_in.is_last),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .verdict       (result_out.verdict),
    .bracket_count (result_out.bracket_count)
);

// ===== tb/sv/tb_bracket_balance_checker_top.sv =====
// self-checking testbench for the bracket balance checker top level
`timescale 1ns / 1ps

module tb_bracket_balance_checker_top;

    // overall run limit, well above the slowest correct run
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // characters wanted over the whole run
    localparam int RUN_ITEMS = 1700;
    // cycles to wait after the last result for any stray result request
    localparam int DRAIN_CYCLES = 12;

    logic clk;
    logic rst_n;

    bbc_in_if  char_in ();
    bbc_out_if result_out ();

    bracket_balance_checker_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .result_out (result_out)
    );

    // one character byte
    typedef logic [bbc_pkg::CHAR_W-1:0] char_t;

    // one expected result request: verdict and saturated bracket count
    typedef struct {
        logic [bbc_pkg::VERD_W-1:0]  verdict;
        logic [bbc_pkg::COUNT_W-1:0] bracket_count;
    } verdict_rec_t;

    // ------------------------------------------------------------------
    // scoreboard: tracks the bracket stack of the current expression and
    // queues the verdict that each last character should produce
    // ------------------------------------------------------------------
    class verdict_scoreboard;
        logic [1:0]                  shape_stack [bbc_pkg::STACK_DEPTH];
        int unsigned                 depth;
        bit                          mismatch;
        bit                          overflow;
        logic [bbc_pkg::COUNT_W-1:0] total;
        verdict_rec_t                awaited_verdicts [$];
        int                          errors;
        int                          verdicts_seen [3];

        function new();
            depth    = 0;
            mismatch = 0;
            overflow = 0;
            total    = '0;
            errors   = 0;
            foreach (verdicts_seen[i])
                verdicts_seen[i] = 0;
        endfunction

        // accepted character request
        function void note_char(logic [bbc_pkg::CHAR_W-1:0] ch, logic last);
            logic [1:0]   shape;
            bit           opener;
            bit           closer;
            verdict_rec_t rec;
            opener = 0;
            closer = 0;
            shape  = bbc_pkg::SHAPE_BRACE;
            case (ch)
                bbc_pkg::CHAR_LBRACE:   begin opener = 1; shape = bbc_pkg::SHAPE_BRACE;   end
                bbc_pkg::CHAR_LBRACKET: begin opener = 1; shape = bbc_pkg::SHAPE_BRACKET; end
                bbc_pkg::CHAR_LPAREN:   begin opener = 1; shape = bbc_pkg::SHAPE_PAREN;   end
                bbc_pkg::CHAR_RBRACE:   begin closer = 1; shape = bbc_pkg::SHAPE_BRACE;   end
                bbc_pkg::CHAR_RBRACKET: begin closer = 1; shape = bbc_pkg::SHAPE_BRACKET; end
                bbc_pkg::CHAR_RPAREN:   begin closer = 1; shape = bbc_pkg::SHAPE_PAREN;   end
                default:                ;
            endcase
            if ((opener || closer) && total != {bbc_pkg::COUNT_W{1'b1}})
                total++;
            if (opener)
            begin
                if (depth < bbc_pkg::STACK_DEPTH)
                begin
                    shape_stack[depth] = shape;
                    depth++;
                end
                else
                    overflow = 1;
            end
            else if (closer)
            begin
                if (depth == 0)
                    mismatch = 1;
                else
                begin
                    depth--;
                    if (shape_stack[depth] != shape)
                        mismatch = 1;
                end
            end
            if (last)
            begin
                if (overflow)
                    rec.verdict = bbc_pkg::VERDICT_OVERFLOW;
                else if (mismatch || depth != 0)
                    rec.verdict = bbc_pkg::VERDICT_UNBAL;
                else
                    rec.verdict = bbc_pkg::VERDICT_OK;
                rec.bracket_count = total;
                awaited_verdicts.push_back(rec);
                depth    = 0;
                mismatch = 0;
                overflow = 0;
                total    = '0;
            end
        endfunction

        // accepted result request
        function void check_result(logic [bbc_pkg::VERD_W-1:0] verdict,
                                   logic [bbc_pkg::COUNT_W-1:0] count);
            verdict_rec_t rec;
            if (awaited_verdicts.size() == 0)
            begin
                $error("unexpected result: verdict %0d, bracket_count %0d", verdict, count);
                errors++;
                return;
            end
            rec = awaited_verdicts.pop_front();
            if (verdict < 3)
                verdicts_seen[verdict]++;
            if (verdict !== rec.verdict)
            begin
                $error("verdict: expected %0d, got %0d", rec.verdict, verdict);
                errors++;
            end
            if (count !== rec.bracket_count)
            begin
                $error("bracket_count: expected %0d, got %0d", rec.bracket_count, count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_verdicts.size();
        endfunction
    endclass

    verdict_scoreboard sb;

    // idling switches for the sender and the receiver
    bit src_idle;
    bit snk_idle;
    int chars_sent;
    int long_exprs;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // clock, 2 ns period
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // watchdog: a hung handshake ends the run as a failure
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // character helpers
    // ------------------------------------------------------------------
    function automatic logic [1:0] pick_shape();
        logic [1:0] shapes [3];
        shapes = '{bbc_pkg::SHAPE_BRACE, bbc_pkg::SHAPE_BRACKET, bbc_pkg::SHAPE_PAREN};
        return shapes[$urandom_range(0, 2)];
    endfunction

    function automatic char_t opener_char(logic [1:0] shape);
        case (shape)
            bbc_pkg::SHAPE_BRACE:   return bbc_pkg::CHAR_LBRACE;
            bbc_pkg::SHAPE_BRACKET: return bbc_pkg::CHAR_LBRACKET;
            default:                return bbc_pkg::CHAR_LPAREN;
        endcase
    endfunction

    function automatic char_t closer_char(logic [1:0] shape);
        case (shape)
            bbc_pkg::SHAPE_BRACE:   return bbc_pkg::CHAR_RBRACE;
            bbc_pkg::SHAPE_BRACKET: return bbc_pkg::CHAR_RBRACKET;
            default:                return bbc_pkg::CHAR_RPAREN;
        endcase
    endfunction

    function automatic bit is_bracket(char_t ch);
        case (ch)
            bbc_pkg::CHAR_LBRACE, bbc_pkg::CHAR_LBRACKET, bbc_pkg::CHAR_LPAREN,
            bbc_pkg::CHAR_RBRACE, bbc_pkg::CHAR_RBRACKET, bbc_pkg::CHAR_RPAREN: return 1'b1;
            default:                                                           return 1'b0;
        endcase
    endfunction

    // any byte that is not a bracket, byte 0 and 0xff included
    function automatic char_t filler_byte();
        char_t b;
        do
            b = char_t'($urandom_range(0, 255));
        while (is_bracket(b));
        return b;
    endfunction

    // random balanced expression with filler sprinkled in
    function automatic void build_balanced(ref char_t expr [$],
                                           input int n_pairs, input int max_nest);
        logic [1:0] open_shapes [$];
        logic [1:0] shape;
        int         opened;
        opened = 0;
        expr.delete();
        while (opened < n_pairs || open_shapes.size() > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                expr.push_back(filler_byte());
            if (opened < n_pairs && (open_shapes.size() == 0 ||
                (open_shapes.size() < max_nest && $urandom_range(0, 1) == 1)))
            begin
                shape = pick_shape();
                open_shapes.push_back(shape);
                expr.push_back(opener_char(shape));
                opened++;
            end
            else
                expr.push_back(closer_char(open_shapes.pop_back()));
        end
        if (expr.size() == 0 || $urandom_range(0, 3) == 0)
            expr.push_back(filler_byte());
    endfunction

    // one random edit that usually breaks the balance
    function automatic void corrupt_expr(ref char_t expr [$]);
        int pos;
        pos = $urandom_range(0, expr.size() - 1);
        case ($urandom_range(0, 3))
            0:
            begin
                if ($urandom_range(0, 1) == 1)
                    expr[pos] = closer_char(pick_shape());
                else
                    expr[pos] = opener_char(pick_shape());
            end
            1:
            begin
                if (expr.size() > 1)
                    expr.delete(pos);
            end
            2:       expr.insert(pos, closer_char(pick_shape()));
            default: expr.insert(pos, opener_char(pick_shape()));
        endcase
    endfunction

    // short burst of arbitrary bytes, half of them brackets
    function automatic void build_noise(ref char_t expr [$]);
        int len;
        len = $urandom_range(1, 12);
        expr.delete();
        repeat (len)
        begin
            if ($urandom_range(0, 1) == 1)
                expr.push_back(char_t'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1) == 1)
                expr.push_back(opener_char(pick_shape()));
            else
                expr.push_back(closer_char(pick_shape()));
        end
    endfunction

    // a run of openers then closers that pop what the stack kept
    function automatic void build_deep(ref char_t expr [$],
                                       input int n_open, input int n_close);
        logic [1:0] kept [$];
        logic [1:0] shape;
        expr.delete();
        repeat (n_open)
        begin
            shape = pick_shape();
            if (kept.size() < bbc_pkg::STACK_DEPTH)
                kept.push_back(shape);
            expr.push_back(opener_char(shape));
        end
        repeat (n_close)
        begin
            if (kept.size() > 0)
                expr.push_back(closer_char(kept.pop_back()));
            else
                expr.push_back(closer_char(pick_shape()));
        end
        if ($urandom_range(0, 1) == 1)
            expr.push_back(filler_byte());
    endfunction

    // ------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------

    // one character request, with an optional idle burst in front
    task automatic send_char(input char_t ch, input logic last);
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            char_in.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        char_in.valid     <= 1'b1;
        char_in.char_code <= ch;
        char_in.is_last   <= last;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        sb.note_char(ch, last);
        chars_sent++;
    endtask

    task automatic send_expr(ref char_t expr [$]);
        foreach (expr[i])
            send_char(expr[i], i == expr.size() - 1);
    endtask

    // sender stays quiet until every outstanding result has come back
    task automatic hold_until_drained();
        char_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------
    // receiver: checks each accepted result and stalls in random bursts
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_out.valid && result_out.ready)
                sb.check_result(result_out.verdict, result_out.bracket_count);
            if (stall_left > 0)
            begin
                stall_left--;
                result_out.ready <= 1'b0;
            end
            else if (snk_idle && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                result_out.ready <= 1'b0;
            end
            else
                result_out.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        char_t expr [$];
        int    expr_count;
        int    kind;

        sb         = new();
        src_idle   = 1'b1;
        snk_idle   = 1'b1;
        chars_sent = 0;
        long_exprs = 0;
        expr_count = 0;

        rst_n             <= 1'b0;
        char_in.valid     <= 1'b0;
        char_in.char_code <= '0;
        char_in.is_last   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every bracket shape nested, mismatch, close on an empty
        // stack, leftover opener, byte 0 and 0xff, filler around brackets
        expr = '{bbc_pkg::CHAR_LBRACE, bbc_pkg::CHAR_LBRACKET, bbc_pkg::CHAR_LPAREN,
                 bbc_pkg::CHAR_RPAREN, bbc_pkg::CHAR_RBRACKET, bbc_pkg::CHAR_RBRACE};
        send_expr(expr);
        expr = '{bbc_pkg::CHAR_LPAREN, bbc_pkg::CHAR_RBRACKET};
        send_expr(expr);
        expr = '{bbc_pkg::CHAR_RPAREN, bbc_pkg::CHAR_LPAREN, bbc_pkg::CHAR_RPAREN};
        send_expr(expr);
        expr = '{bbc_pkg::CHAR_LBRACKET, 8'h00};
        send_expr(expr);
        expr = '{8'hFF};
        send_expr(expr);
        expr = '{8'h00};
        send_expr(expr);
        expr = '{8'h61, bbc_pkg::CHAR_LBRACE, bbc_pkg::CHAR_RBRACE, 8'h78};
        send_expr(expr);
        expr = '{bbc_pkg::CHAR_RBRACE};
        send_expr(expr);
        hold_until_drained();

        // random part: mostly well-formed expressions, some broken, some noise
        while (chars_sent < RUN_ITEMS)
        begin
            // last stretch of the run goes flat out on both sides
            if (chars_sent > RUN_ITEMS * 85 / 100)
            begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end
            else
            begin
                src_idle = ($urandom_range(0, 4) != 0);
                snk_idle = ($urandom_range(0, 4) != 0);
            end

            kind = $urandom_range(0, 9);
            if (kind < 6)
                build_balanced(expr, $urandom_range(0, 10), $urandom_range(1, 12));
            else if (kind < 9)
            begin
                build_balanced(expr, $urandom_range(1, 10), $urandom_range(1, 12));
                corrupt_expr(expr);
            end
            else
                build_noise(expr);
            send_expr(expr);
            expr_count++;

            if ($urandom_range(0, 19) == 0)
                hold_until_drained();

            // one long expression early on: stack fills, overflows, and
            // later closers pop what it kept
            if (expr_count == 10)
            begin
                src_idle = 1'b0;
                hold_until_drained();
                build_deep(expr, bbc_pkg::STACK_DEPTH + 2, 6);
                send_expr(expr);
                long_exprs += 1;
                hold_until_drained();
            end
        end

        // everything sent: let the results drain, then look for strays
        char_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d random and 8 directed expressions, %0d of them long",
                 chars_sent, expr_count, long_exprs);
        $display("verdicts checked: %0d balanced, %0d unbalanced, %0d overflow",
                 sb.verdicts_seen[bbc_pkg::VERDICT_OK], sb.verdicts_seen[bbc_pkg::VERDICT_UNBAL],
                 sb.verdicts_seen[bbc_pkg::VERDICT_OVERFLOW]);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
